// File: rtl/tedet_pkg.sv
// shared types and constants of the text encoding detector
// byte order mark table, encoding codes and the scan snapshot struct
// no dependencies
package tedet_pkg;

    // encoding codes as reported on the result channel
    typedef enum logic [3:0] {
        ENC_UNKNOWN = 4'd0,
        ENC_UTF8    = 4'd1,
        ENC_WIN1252 = 4'd2,
        ENC_U16LE   = 4'd3,
        ENC_U16BE   = 4'd4,
        ENC_U32LE   = 4'd5,
        ENC_U32BE   = 4'd6,
        ENC_UTF7    = 4'd7,
        ENC_UTF1    = 4'd8,
        ENC_EBCDIC  = 4'd9,
        ENC_SCSU    = 4'd10,
        ENC_BOCU1   = 4'd11,
        ENC_GB18030 = 4'd12
    } enc_t;

    localparam int MarkCount = 11;

    // mark bytes, first byte in the lowest bits
    localparam logic [MarkCount-1:0][31:0] MARK_BYTES = '{
        32'h3395_3184,   // gb18030
        32'h0028_EEFB,   // bocu-1
        32'h00FF_FE0E,   // scsu
        32'h7366_73DD,   // utf-ebcdic
        32'h004C_64F7,   // utf-1
        32'h0076_2F2B,   // utf-7
        32'hFFFE_0000,   // utf-32be
        32'h0000_FEFF,   // utf-16le
        32'h0000_FFFE,   // utf-16be
        32'h00BF_BBEF,   // utf-8
        32'h0000_FEFF    // utf-32le
    };

    localparam logic [MarkCount-1:0][2:0] MARK_LEN = '{
        3'd4, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4
    };

    localparam enc_t [MarkCount-1:0] MARK_CODE = '{
        ENC_GB18030, ENC_BOCU1, ENC_SCSU, ENC_EBCDIC, ENC_UTF1, ENC_UTF7,
        ENC_U32BE, ENC_U16LE, ENC_U16BE, ENC_UTF8, ENC_U32LE
    };

    // utf-7 fourth byte choices
    localparam logic [7:0] UTF7_TAIL_8     = 8'h38;
    localparam logic [7:0] UTF7_TAIL_9     = 8'h39;
    localparam logic [7:0] UTF7_TAIL_PLUS  = 8'h2B;
    localparam logic [7:0] UTF7_TAIL_SLASH = 8'h2F;

    // buffer state after the final byte, handed to the verdict logic
    typedef struct packed {
        logic [3:0][7:0] head;
        logic [2:0]      head_count;
        logic [1:0]      len_mod;
        logic [3:0]      and_quad;
        logic [3:0]      or_quad;
        logic [1:0]      and_pair;
        logic [1:0]      or_pair;
        logic            utf8_good;
    } scan_t;

endpackage

// File: rtl/tedet_utf8.sv
// rfc 3629 validity tracker of the text encoding detector
// steps once per byte and reports whether the buffer so far is good utf-8
// no dependencies
module tedet_utf8 (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,        // a byte is processed this cycle
    input  logic       clear,       // that byte ends the buffer
    input  logic [7:0] data_byte,
    input  logic       accept_tail,
    output logic       good         // verdict including this byte
);

    typedef enum logic [2:0] {
        LIM_NONE  = 3'd0,
        LIM_A0_BF = 3'd1,
        LIM_80_9F = 3'd2,
        LIM_90_BF = 3'd3,
        LIM_80_8F = 3'd4
    } limit_t;

    logic [1:0] pending_reg, pending_next;
    limit_t     limit_reg, limit_next;
    logic       ok_reg, ok_next;
    logic [7:0] lo, hi;

    // continuation window for the pending byte
    always_comb
    begin
        lo = 8'h80;
        hi = 8'hBF;
        unique case (limit_reg)
            LIM_A0_BF: lo = 8'hA0;
            LIM_80_9F: hi = 8'h9F;
            LIM_90_BF: lo = 8'h90;
            LIM_80_8F: hi = 8'h8F;
            default:   ;
        endcase
    end

    // sequence decoder
    always_comb
    begin
        pending_next = pending_reg;
        limit_next   = LIM_NONE;
        ok_next      = ok_reg;
        if (pending_reg != 2'd0) begin
            if (data_byte < lo || data_byte > hi) begin
                ok_next      = 1'b0;
                pending_next = 2'd0;
            end else begin
                pending_next = pending_reg - 2'd1;
            end
        end else if (data_byte < 8'h80) begin
            ok_next = ok_reg;
        end else if (data_byte < 8'hC2) begin
            ok_next = 1'b0;
        end else if (data_byte < 8'hE0) begin
            pending_next = 2'd1;
        end else if (data_byte < 8'hF0) begin
            pending_next = 2'd2;
            if (data_byte == 8'hE0) limit_next = LIM_A0_BF;
            else if (data_byte == 8'hED) limit_next = LIM_80_9F;
        end else if (data_byte < 8'hF5) begin
            pending_next = 2'd3;
            if (data_byte == 8'hF0) limit_next = LIM_90_BF;
            else if (data_byte == 8'hF4) limit_next = LIM_80_8F;
        end else begin
            ok_next = 1'b0;
        end
    end

    // open sequence at the end counts only when the tail is accepted
    assign good = ok_next && (pending_next == 2'd0 || accept_tail);

    // tracker state, back to reset at buffer end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pending_reg <= 2'd0;
            limit_reg   <= LIM_NONE;
            ok_reg      <= 1'b1;
        end else if (step) begin
            if (clear) begin
                pending_reg <= 2'd0;
                limit_reg   <= LIM_NONE;
                ok_reg      <= 1'b1;
            end else begin
                pending_reg <= pending_next;
                limit_reg   <= limit_next;
                ok_reg      <= ok_next;
            end
        end
    end

endmodule

// File: rtl/tedet_verdict.sv
// verdict logic of the text encoding detector
// byte order mark match in table order, then zero pattern decode
// depends on tedet_pkg
module tedet_verdict (
    input  tedet_pkg::scan_t scan,
    output tedet_pkg::enc_t  code,
    output logic [2:0]       mark_length
);

    logic [tedet_pkg::MarkCount-1:0] hit;
    logic                            found;
    tedet_pkg::enc_t                 mark_code;
    logic [2:0]                      mark_len;
    tedet_pkg::enc_t                 e_and, e_or;
    logic [7:0]                      tail;

    function automatic tedet_pkg::enc_t decode_quad(input logic [3:0] p);
        case (p)
            4'h1, 4'h3: decode_quad = tedet_pkg::ENC_U32LE;
            4'h5:       decode_quad = tedet_pkg::ENC_U16LE;
            4'h8, 4'hC: decode_quad = tedet_pkg::ENC_U32BE;
            4'hA:       decode_quad = tedet_pkg::ENC_U16BE;
            4'hF:       decode_quad = tedet_pkg::ENC_UTF8;
            default:    decode_quad = tedet_pkg::ENC_UNKNOWN;
        endcase
    endfunction

    function automatic tedet_pkg::enc_t decode_pair(input logic [1:0] p);
        case (p)
            2'h1:    decode_pair = tedet_pkg::ENC_U16LE;
            2'h2:    decode_pair = tedet_pkg::ENC_U16BE;
            2'h3:    decode_pair = tedet_pkg::ENC_UTF8;
            default: decode_pair = tedet_pkg::ENC_UNKNOWN;
        endcase
    endfunction

    assign tail = scan.head[3];

    // per-entry mark compare, only over bytes the entry uses
    always_comb
    begin
        for (int i = 0; i < tedet_pkg::MarkCount; i++) begin
            hit[i] = scan.head_count >= tedet_pkg::MARK_LEN[i];
            for (int k = 0; k < 4; k++) begin
                if (k < int'(tedet_pkg::MARK_LEN[i]) &&
                    scan.head[k] != tedet_pkg::MARK_BYTES[i][8*k +: 8])
                    hit[i] = 1'b0;
            end
            // utf-7 needs a fourth byte from its short list
            if (tedet_pkg::MARK_CODE[i] == tedet_pkg::ENC_UTF7) begin
                if (scan.head_count < 3'd4 ||
                    !(tail == tedet_pkg::UTF7_TAIL_8 || tail == tedet_pkg::UTF7_TAIL_9 ||
                      tail == tedet_pkg::UTF7_TAIL_PLUS ||
                      tail == tedet_pkg::UTF7_TAIL_SLASH))
                    hit[i] = 1'b0;
            end
        end
    end

    // hit with the lowest table index wins, i.e. the entry listed last in the package
    always_comb
    begin
        found     = 1'b0;
        mark_code = tedet_pkg::ENC_UNKNOWN;
        mark_len  = 3'd0;
        for (int i = tedet_pkg::MarkCount - 1; i >= 0; i--) begin
            if (hit[i]) begin
                found     = 1'b1;
                mark_code = tedet_pkg::MARK_CODE[i];
                mark_len  = tedet_pkg::MARK_LEN[i];
            end
        end
    end

    // pattern decode chosen by length modulo four
    always_comb
    begin
        case (scan.len_mod)
            2'd0:
            begin
                e_and = decode_quad(scan.and_quad);
                e_or  = decode_quad(scan.or_quad);
            end
            2'd2:
            begin
                e_and = decode_pair(scan.and_pair);
                e_or  = decode_pair(scan.or_pair);
            end
            default:
            begin
                e_and = tedet_pkg::ENC_UTF8;
                e_or  = tedet_pkg::ENC_UTF8;
            end
        endcase
    end

    // final choice
    always_comb
    begin
        mark_length = 3'd0;
        if (found) begin
            code        = mark_code;
            mark_length = mark_len;
        end else if (e_and != e_or) begin
            code = tedet_pkg::ENC_UNKNOWN;
        end else if (e_and != tedet_pkg::ENC_UTF8) begin
            code = e_and;
        end else if (scan.utf8_good) begin
            code = tedet_pkg::ENC_UTF8;
        end else begin
            code = tedet_pkg::ENC_WIN1252;
        end
    end

endmodule

// File: rtl/text_encoding_detector.sv
// text encoding detector, top level
// input register, per-byte scan state, verdict logic and result register
// depends on tedet_pkg, tedet_utf8, tedet_verdict
//
// usage
// - the slave stream carries one buffer byte per request; tlast marks the
//   final byte of a buffer. only the final byte produces a result request.
// - the master stream returns one result per buffer: encoding code and the
//   number of byte order mark bytes to skip.
// - one byte per cycle sustained unless a final byte is held back: each byte
//   sits in the input register while the scan state and the verdict are
//   updated by small compare logic, then the verdict goes to the result register.
// - a final byte moves from the input register into the result register
//   once the result register is free.
// - when the receiver stalls with a result pending, bytes that are not the
//   end of a buffer keep flowing; a further final byte waits in the input
//   register and the slave side stops only then.
// - reset clears the scan state and both stages; the tail acceptance
//   register resets to one and is written through cfg_wen / cfg_wdata.
// - every buffer end returns the scan state to reset, so the next byte
//   starts a new buffer.
module text_encoding_detector (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_wen,
    input  logic       cfg_wdata,      // accept_truncated_tail
    // byte stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,        // [7:0] data_byte
    input  logic       s_tlast,        // last_byte
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata         // [3:0] encoding_code, [6:4] mark_length, [7] zero
);

    logic            accept_tail_reg;
    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    logic            in_last_reg;
    logic            advance;

    logic [3:0][7:0] head_reg, head_next;
    logic [2:0]      head_count_reg, head_count_next;
    logic [1:0]      len_mod_reg, len_mod_next;
    logic [3:0]      group_reg, group_next;
    logic [3:0]      and_quad_reg, and_quad_next;
    logic [3:0]      or_quad_reg, or_quad_next;
    logic [1:0]      and_pair_reg, and_pair_next;
    logic [1:0]      or_pair_reg, or_pair_next;
    logic [1:0]      pair_bits;
    logic            utf8_good;

    tedet_pkg::scan_t scan;
    tedet_pkg::enc_t  code;
    logic [2:0]       mark_len;

    logic            out_valid_reg;
    logic [3:0]      out_code_reg;
    logic [2:0]      out_len_reg;

    // a final byte moves on only when the result register is free
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            accept_tail_reg <= 1'b1;
        else if (cfg_wen)
            accept_tail_reg <= cfg_wdata;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // head bytes and zero patterns
    always_comb
    begin
        head_next       = head_reg;
        head_count_next = head_count_reg;
        if (head_count_reg < 3'd4) begin
            head_next[head_count_reg[1:0]] = in_byte_reg;
            head_count_next                = head_count_reg + 3'd1;
        end

        group_next = (len_mod_reg == 2'd0) ? 4'd0 : group_reg;
        if (in_byte_reg != 8'd0)
            group_next[len_mod_reg] = 1'b1;

        pair_bits     = len_mod_reg[1] ? group_next[3:2] : group_next[1:0];
        and_pair_next = and_pair_reg;
        or_pair_next  = or_pair_reg;
        if (len_mod_reg[0]) begin
            and_pair_next = and_pair_reg & pair_bits;
            or_pair_next  = or_pair_reg | pair_bits;
        end

        and_quad_next = and_quad_reg;
        or_quad_next  = or_quad_reg;
        if (len_mod_reg == 2'd3) begin
            and_quad_next = and_quad_reg & group_next;
            or_quad_next  = or_quad_reg | group_next;
        end

        len_mod_next = len_mod_reg + 2'd1;
    end

    // scan state, back to reset at buffer end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_count_reg <= 3'd0;
            len_mod_reg    <= 2'd0;
            group_reg      <= 4'd0;
            and_quad_reg   <= 4'hF;
            or_quad_reg    <= 4'h0;
            and_pair_reg   <= 2'h3;
            or_pair_reg    <= 2'h0;
        end else if (advance) begin
            if (in_last_reg) begin
                head_count_reg <= 3'd0;
                len_mod_reg    <= 2'd0;
                group_reg      <= 4'd0;
                and_quad_reg   <= 4'hF;
                or_quad_reg    <= 4'h0;
                and_pair_reg   <= 2'h3;
                or_pair_reg    <= 2'h0;
            end else begin
                head_count_reg <= head_count_next;
                len_mod_reg    <= len_mod_next;
                group_reg      <= group_next;
                and_quad_reg   <= and_quad_next;
                or_quad_reg    <= or_quad_next;
                and_pair_reg   <= and_pair_next;
                or_pair_reg    <= or_pair_next;
            end
        end
    end

    // head bytes hold no reset, only entries below the count are read
    always_ff @(posedge clk)
    begin
        if (advance)
            head_reg <= head_next;
    end

    // utf-8 validity tracker
    tedet_utf8 u_utf8 (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .clear       (in_last_reg),
        .data_byte   (in_byte_reg),
        .accept_tail (accept_tail_reg),
        .good        (utf8_good)
    );

    // verdict from the state including the final byte
    always_comb
    begin
        scan.head       = head_next;
        scan.head_count = head_count_next;
        scan.len_mod    = len_mod_next;
        scan.and_quad   = and_quad_next;
        scan.or_quad    = or_quad_next;
        scan.and_pair   = and_pair_next;
        scan.or_pair    = or_pair_next;
        scan.utf8_good  = utf8_good;
    end

    tedet_verdict u_verdict (
        .scan        (scan),
        .code        (code),
        .mark_length (mark_len)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg) begin
            out_code_reg <= code;
            out_len_reg  <= mark_len;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_len_reg, out_code_reg};

endmodule
